// ===== hw/rtl/value_frequency_table_core_assert.svh =====
// ----------------------------------------------------------------------------
// Value frequency table assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VALUE_FREQUENCY_TABLE_CORE_ASSERT_SVH
`define VALUE_FREQUENCY_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define VFT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vft assertion failed");
// Check that an antecedent implies a consequent in the same cycle.
`define VFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vft implication failed");
`else
`define VFT_ASSERT(label, clk, rst_n, prop)
`define VFT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/vft_pkg.sv =====
// ----------------------------------------------------------------------------
// Value frequency table package
// Word types, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package vft_pkg;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [2:0] ST_NEW         = 3'd0;
  localparam logic [2:0] ST_INCREMENTED = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_READ_OK     = 3'd3;
  localparam logic [2:0] ST_UNUSED      = 3'd4;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] value;
    logic        [3:0]  index;
  } vft_in_t;

  typedef struct packed {
    logic signed [31:0] entry_value;
    logic        [31:0] entry_count;
    logic        [2:0]  status;
    logic        [4:0]  used_entries;
  } vft_out_t;

  // One table row: stored value and its occurrence count.
  typedef struct packed {
    logic [31:0] value;
    logic [31:0] count;
  } vft_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_RDWAIT,
    S_DONE
  } vft_state_e;

endpackage

// ===== hw/rtl/vft_mem.sv =====
// ----------------------------------------------------------------------------
// Value frequency table memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vft_mem import vft_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int AW      = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  vft_entry_t    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output vft_entry_t    rdata_o
);

  vft_entry_t mem_q [ENTRIES];
  vft_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/vft_ctrl.sv =====
// ----------------------------------------------------------------------------
// Value frequency table sequencer
// Scan the table one entry a cycle through a shared compare and increment.
// ----------------------------------------------------------------------------
`include "value_frequency_table_core_assert.svh"

module vft_ctrl import vft_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int AW      = 4,
  parameter int FW      = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vft_in_t       in_data_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output vft_out_t      res_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output vft_entry_t    mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  vft_entry_t    mem_rdata_i
);

  vft_state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] ptr_q, ptr_d;
  vft_in_t item_q;
  vft_out_t res_q, res_d;
  logic res_ld, item_ld;

  // Shared compare and saturating increment unit.
  logic        hit_w;
  logic [31:0] cnt_inc_w;
  logic [FW-1:0] ptr_next_w;
  logic        last_w;
  logic        idx_ok_w;
  logic        full_w;

  assign hit_w      = (mem_rdata_i.value == item_q.value);
  assign cnt_inc_w  = (mem_rdata_i.count == COUNT_MAX) ? mem_rdata_i.count
                                                       : mem_rdata_i.count + 32'd1;
  assign ptr_next_w = FW'(ptr_q) + FW'(1);
  assign last_w     = (ptr_next_w == fill_q);
  assign idx_ok_w   = (32'(in_data_i.index) < 32'(fill_q)) &&
                      (32'(in_data_i.index) < ENTRIES);
  assign full_w     = (32'(fill_q) >= ENTRIES);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.operation == OP_READ) begin
            state_d = idx_ok_w ? S_RDWAIT : S_DONE;
          end else begin
            state_d = (fill_q == '0) ? S_APPEND : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit_w) begin
          state_d = S_DONE;
        end else if (last_w) begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: state_d = S_DONE;
      S_RDWAIT: state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath controls.
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = '{value: item_q.value, count: cnt_inc_w};
    mem_raddr_o = '0;
    item_ld     = 1'b0;
    res_ld      = 1'b0;
    res_d       = res_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        item_ld     = in_valid_i;
        ptr_d       = '0;
        mem_raddr_o = (in_data_i.operation == OP_READ) ? AW'(in_data_i.index) : '0;
        if (in_valid_i && in_data_i.operation == OP_READ && !idx_ok_w) begin
          res_ld = 1'b1;
          res_d  = '{entry_value: '0, entry_count: '0, status: ST_UNUSED,
                     used_entries: 5'(fill_q)};
        end
      end
      S_SCAN: begin
        mem_raddr_o = AW'(ptr_next_w);
        if (hit_w) begin
          mem_we_o = 1'b1;
          res_ld   = 1'b1;
          res_d    = '{entry_value: mem_rdata_i.value, entry_count: cnt_inc_w,
                       status: ST_INCREMENTED, used_entries: 5'(fill_q)};
        end else begin
          ptr_d = AW'(ptr_next_w);
        end
      end
      S_APPEND: begin
        res_ld = 1'b1;
        if (full_w) begin
          res_d = '{entry_value: item_q.value, entry_count: '0, status: ST_FULL,
                    used_entries: 5'(fill_q)};
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AW'(fill_q);
          mem_wdata_o = '{value: item_q.value, count: 32'd1};
          fill_d      = fill_q + FW'(1);
          res_d       = '{entry_value: item_q.value, entry_count: 32'd1,
                          status: ST_NEW, used_entries: 5'(fill_q + FW'(1))};
        end
      end
      S_RDWAIT: begin
        res_ld = 1'b1;
        res_d  = '{entry_value: mem_rdata_i.value, entry_count: mem_rdata_i.count,
                   status: ST_READ_OK, used_entries: 5'(fill_q)};
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (item_ld) begin
      item_q <= in_data_i;
    end
    if (res_ld) begin
      res_q <= res_d;
    end
  end

  `VFT_ASSERT(a_fill_bound, clk_i, rst_ni, 32'(fill_q) <= ENTRIES)
  `VFT_ASSERT_IMPL(a_write_state, clk_i, rst_ni, mem_we_o,
                   state_q == S_SCAN || state_q == S_APPEND)
  `VFT_ASSERT_IMPL(a_fill_step, clk_i, rst_ni, fill_q != $past(fill_q),
                   fill_q == $past(fill_q) + FW'(1) && $past(state_q) == S_APPEND)
  `VFT_ASSERT_IMPL(a_scan_in_range, clk_i, rst_ni, state_q == S_SCAN,
                   FW'(ptr_q) < fill_q)

endmodule

// ===== hw/rtl/value_frequency_table_core.sv =====
// ----------------------------------------------------------------------------
// Value frequency table core
// Distinct-value table with occurrence counts, searched one entry a cycle.
// ----------------------------------------------------------------------------
//
//   channel | handshake              | word
//   --------+------------------------+-----------------------------------------
//   input   | in_valid_i/in_ready_o  | in_data_i  (operation, value, index)
//   output  | out_valid_o/out_ready_i| out_data_o (entry_value, entry_count,
//           |                        |             status, used_entries)
//
// A count word scans the table until a hit, or through every entry below
// the fill count when it misses; the scan compares one entry per cycle
// through the table memory's single registered read port. A read word
// waits for its entry's registered read data unless the index is unused.
// The core takes one word at a time: in_ready_o is high only while the
// sequencer is idle. A finished result waits in the sequencer until the output
// register is free, so a stalled output holds the sequencer but never drops a
// result. Reset clears the fill count and the control state; table contents
// are undefined until written and only entries below the fill count are read.
// ----------------------------------------------------------------------------
module value_frequency_table_core import vft_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  vft_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output vft_out_t out_data_o
);

  // Address width of the table, and width of the fill count (holds ENTRIES).
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW = $clog2(ENTRIES + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  vft_entry_t    mem_wdata;
  vft_entry_t    mem_rdata;

  logic          res_valid;
  logic          res_ready;
  vft_out_t      res;

  logic          out_valid_q, out_valid_d;
  vft_out_t      out_data_q;

  // Table storage: one row per distinct value, in order of first arrival.
  vft_mem #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer: serve a read, or scan, compare, increment or append; then hand over a result.
  vft_ctrl #(
    .ENTRIES (ENTRIES),
    .AW      (AW),
    .FW      (FW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Output register: take a new result when empty or being drained this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload until the word is taken.
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== dv/value_frequency_table_checker.sv =====
// ----------------------------------------------------------------------------
// Value frequency table checker
// Watches both channels and predicts every result word from the accepted
// input words. Compares each result field by field, in order.
// ----------------------------------------------------------------------------
module value_frequency_table_checker import vft_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  vft_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  vft_out_t out_data_i,
  output int       fails_o,
  output int       pending_o
);

  // Shadow table, in first-seen order.
  logic [31:0] seen_value [ENTRIES];
  logic [31:0] seen_count [ENTRIES];
  int          distinct_count;

  vft_out_t    tally_q[$];
  int          mismatches = 0;
  int          tally_depth = 0;

  assign fails_o   = mismatches;
  assign pending_o = tally_depth;

  // Apply one word to the shadow table and return the result it produces.
  function automatic vft_out_t tally_word(input vft_in_t w);
    vft_out_t r;
    logic     hit;
    hit            = 1'b0;
    r.entry_value  = '0;
    r.entry_count  = '0;
    r.status       = ST_UNUSED;
    if (w.operation == OP_READ) begin
      if (int'(w.index) < distinct_count) begin
        r.entry_value = seen_value[w.index];
        r.entry_count = seen_count[w.index];
        r.status      = ST_READ_OK;
      end
    end else begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (!hit && k < distinct_count && seen_value[k] == w.value) begin
          hit = 1'b1;
          if (seen_count[k] != COUNT_MAX) begin
            seen_count[k] = seen_count[k] + 32'd1;
          end
          r.entry_value = seen_value[k];
          r.entry_count = seen_count[k];
          r.status      = ST_INCREMENTED;
        end
      end
      if (!hit) begin
        r.entry_value = w.value;
        if (distinct_count < ENTRIES) begin
          seen_value[distinct_count] = w.value;
          seen_count[distinct_count] = 32'd1;
          distinct_count             = distinct_count + 1;
          r.entry_count              = 32'd1;
          r.status                   = ST_NEW;
        end else begin
          r.status = ST_FULL;
        end
      end
    end
    r.used_entries = 5'(distinct_count);
    return r;
  endfunction

  task automatic compare_word(input vft_out_t want, input vft_out_t got);
    if (got.entry_value !== want.entry_value) begin
      $error("entry_value: expected %0d, got %0d", want.entry_value, got.entry_value);
      mismatches++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.used_entries !== want.used_entries) begin
      $error("used_entries: expected %0d, got %0d", want.used_entries, got.used_entries);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      distinct_count = 0;
      tally_q.delete();
      tally_depth = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (tally_q.size() == 0) begin
          $error("result word with no word expected");
          mismatches++;
        end else begin
          compare_word(tally_q.pop_front(), out_data_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        tally_q.insert(tally_q.size(), tally_word(in_data_i));
      end
      tally_depth = tally_q.size();
    end
  end

endmodule

// ===== dv/value_frequency_table_core_test.sv =====
// ----------------------------------------------------------------------------
// Value frequency table core test
// Drives count and read words through the core with random idling on both
// channels; a checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module value_frequency_table_core_test;
  import vft_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int PHASE_WORDS = 470;
  localparam int POOL_SIZE   = 20;
  // Longest stretch without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT = 1000;
  // Cycles to wait after the last result, so that any straggler is still caught.
  localparam int TAIL_CYCLES = 40;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  vft_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  vft_out_t out_data_o;

  int          fails;
  int          pending;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          quiet_cycles = 0;
  logic [31:0] value_pool [POOL_SIZE];

  value_frequency_table_core #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  value_frequency_table_checker #(
    .ENTRIES(ENTRIES)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .fails_o    (fails),
    .pending_o  (pending)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: decide readiness for the coming edge at every falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: reset the count on any handshake, give up after a long silence.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("value_frequency_table_core_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic vft_in_t count_word(input logic [31:0] v);
    vft_in_t w;
    w.operation = OP_COUNT;
    w.value     = v;
    w.index     = 4'($urandom);
    return w;
  endfunction

  function automatic vft_in_t read_word(input logic [3:0] idx);
    vft_in_t w;
    w.operation = OP_READ;
    w.value     = $urandom;
    w.index     = idx;
    return w;
  endfunction

  // Mostly values from a small pool so that hits are common; the rest are
  // fully random to toggle every value bit and to provoke table-full drops.
  function automatic vft_in_t random_word();
    vft_in_t w;
    w.operation = ($urandom_range(99) < 25) ? OP_READ : OP_COUNT;
    w.index     = 4'($urandom);
    if ($urandom_range(99) < 85) begin
      w.value = value_pool[$urandom_range(POOL_SIZE - 1)];
    end else begin
      w.value = $urandom;
    end
    return w;
  endfunction

  // Idle for a random number of cycles with junk on the data lines, then
  // present the word and hold it until the core takes it.
  task automatic send_word(input vft_in_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= random_word();
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and hold off until every expected result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    tx_idle_pct = 15;
    rx_idle_pct = 51;

    // Seed the pool with the extremes and a few small values; the rest is random.
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    value_pool[4] = 32'h0000_0001;
    for (int k = 5; k < POOL_SIZE; k++) begin
      value_pool[k] = $urandom;
    end

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reads of an empty table, both extremes, repeats, reads of
    // filled and unused entries. The table-full drop comes early in the
    // random part once more than ENTRIES distinct values have been counted.
    // Count saturation needs 2^32 - 1 hits on one entry and is out of reach
    // through the ports.
    send_word(read_word(4'd0));
    send_word(read_word(4'd15));
    send_word(count_word(32'h8000_0000));
    send_word(count_word(32'h7FFF_FFFF));
    send_word(count_word(32'h8000_0000));
    send_word(count_word(32'h0000_0000));
    send_word(count_word(32'hFFFF_FFFF));
    send_word(count_word(32'h7FFF_FFFF));
    send_word(read_word(4'd0));
    send_word(read_word(4'd1));
    send_word(read_word(4'd3));
    send_word(read_word(4'd4));
    send_word(read_word(4'd15));
    send_word(count_word(32'hFFFF_FFFF));
    drain();

    // Random: sender-light idling, then receiver-light, then none at all.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 51;
        end
        1: begin
          tx_idle_pct = 51;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word());
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("value_frequency_table_core_test: done, clean");
    end else begin
      $display("value_frequency_table_core_test: done, errors");
    end
    $finish;
  end

endmodule
